[src/kfef_pkg.sv]
// Shared types and constants for the Kruskal forest edge filter.
`timescale 1ns / 1ps

package kfef_pkg;

  localparam int unsigned VtxW     = 8;
  localparam int unsigned CntW     = 8;
  localparam int unsigned VcW      = 9;
  localparam int unsigned WeightW  = 32;
  localparam logic [VcW-1:0] VcReset = 9'd256;

  // One edge word on the input channel.
  typedef struct packed {
    logic                       first_edge;
    logic [VtxW-1:0]            source;
    logic [VtxW-1:0]            destination;
    logic signed [WeightW-1:0]  weight;
  } in_word_t;

  // One result word on the output channel.
  typedef struct packed {
    logic                       accepted;
    logic [VtxW-1:0]            low_end;
    logic [VtxW-1:0]            high_end;
    logic signed [WeightW-1:0]  edge_weight;
    logic [CntW-1:0]            edges_taken;
    logic                       tree_complete;
  } out_word_t;

  // Parent table access requests.
  typedef struct packed {
    logic            en;
    logic [VtxW-1:0] addr;
  } tbl_rd_t;

  typedef struct packed {
    logic            en;
    logic            clear;
    logic [VtxW-1:0] addr;
    logic [VtxW-1:0] data;
  } tbl_wr_t;

endpackage

[src/kfef_if.sv]
// Valid/ready channel interfaces for edge input, result output and configuration.
`timescale 1ns / 1ps

interface kfef_in_if;
  logic               valid;
  logic               ready;
  kfef_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface kfef_out_if;
  logic                valid;
  logic                ready;
  kfef_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface kfef_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [kfef_pkg::VcW-1:0]   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/kfef_parent_table.sv]
// Union-find parent table: memory with one read port, one write port and per-entry valid bits.
`timescale 1ns / 1ps

module kfef_parent_table #(
  parameter int unsigned Depth = 256,
  parameter int unsigned IdxW  = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  kfef_pkg::tbl_rd_t          rd_req_i,
  input  kfef_pkg::tbl_wr_t          wr_req_i,
  output logic [kfef_pkg::VtxW-1:0]  rd_data_o
);

  logic [kfef_pkg::VtxW-1:0] mem_q [Depth];
  logic [Depth-1:0]          valid_q;
  logic [kfef_pkg::VtxW-1:0] rd_data_q;
  logic [IdxW-1:0]           rd_addr_q;
  logic                      rd_hit_q;

  // Payload storage, no reset.
  always_ff @(posedge clk_i) begin
    if (wr_req_i.en) begin
      mem_q[wr_req_i.addr[IdxW-1:0]] <= wr_req_i.data;
    end
    if (rd_req_i.en) begin
      rd_data_q <= mem_q[rd_req_i.addr[IdxW-1:0]];
      rd_addr_q <= rd_req_i.addr[IdxW-1:0];
    end
  end

  // Entry not yet written since clear reads as its own index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_hit_q <= 1'b0;
    end else begin
      if (wr_req_i.clear) begin
        valid_q <= '0;
      end else if (wr_req_i.en) begin
        valid_q[wr_req_i.addr[IdxW-1:0]] <= 1'b1;
      end
      if (rd_req_i.en) begin
        rd_hit_q <= valid_q[rd_req_i.addr[IdxW-1:0]];
      end
    end
  end

  assign rd_data_o = rd_hit_q ? rd_data_q : kfef_pkg::VtxW'(rd_addr_q);

endmodule

[src/kruskal_forest_edge_filter_unit.sv]
// Top level of the Kruskal forest edge filter: sequencer, count and result register.
`timescale 1ns / 1ps

// Usage:
//  in_i   : one edge word per handshake (first_edge, source, destination, weight).
//           Edges must arrive in ascending weight order; first_edge starts a new graph.
//  out_o  : one result word per edge: accepted flag, ordered endpoints, weight,
//           running count of taken edges and tree_complete.
//  cfg_i  : vertex_count write (always ready); write it only while idle.
// Sequencing: the sequencer walks both parent chains through a table with one
//  read and one write port, reading then comparing each vertex visited; each
//  walk stops after 256 links. An edge rejected up front (endpoint out of range
//  or tree done) skips both walks and goes straight to the finish state.
//  in_i.ready is high only while the sequencer is idle; one edge at a time, and
//  the next edge can be taken the cycle after the result word is loaded.
// The result register lets the next edge be taken while the previous word
//  waits; if out_o stalls, the finished edge holds in the sequencer until the
//  register frees.
// Reset: vertex_count = 256, count = 0, every table entry reads as its own
//  index (valid bits cleared at once, no clearing pass). first_edge does the same
//  to the forest and count.
module kruskal_forest_edge_filter_unit #(
  parameter int unsigned MAX_VERTICES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  kfef_in_if.sink     in_i,
  kfef_out_if.source  out_o,
  kfef_cfg_if.sink    cfg_i
);

  localparam int unsigned Depth = (MAX_VERTICES < 256) ? MAX_VERTICES : 256;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam logic [kfef_pkg::VcW-1:0] Cap = kfef_pkg::VcW'(Depth);
  // Link steps after which a walk stops regardless of the table contents.
  localparam logic [8:0] StepMax = 9'd256;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_DONE
  } state_e;

  state_e                          state_q;
  logic                            phase_q;    // 0: source walk, 1: destination walk
  logic [kfef_pkg::VtxW-1:0]       v_q;
  logic [kfef_pkg::VtxW-1:0]       rs_q;
  logic [kfef_pkg::VtxW-1:0]       src_q;
  logic [kfef_pkg::VtxW-1:0]       dst_q;
  logic signed [kfef_pkg::WeightW-1:0] weight_q;
  logic [kfef_pkg::VcW-1:0]        vc_q;
  logic [kfef_pkg::VcW-1:0]        n_q;
  logic [kfef_pkg::CntW-1:0]       need_q;
  logic [kfef_pkg::CntW-1:0]       taken_q;
  logic [8:0]                      steps_q;
  logic                            acc_q;
  logic                            out_valid_q;
  kfef_pkg::out_word_t             out_q;

  logic [kfef_pkg::VcW-1:0]        n_d;
  logic [kfef_pkg::CntW-1:0]       need_d;
  logic [kfef_pkg::CntW-1:0]       taken_start;
  logic                            edge_ok;
  logic                            in_fire;
  logic                            is_root;
  logic                            walk_end;
  logic                            out_load;
  logic [kfef_pkg::VtxW-1:0]       parent;
  logic [kfef_pkg::VtxW-1:0]       rd_data;
  kfef_pkg::tbl_rd_t               rd_req;
  kfef_pkg::tbl_wr_t               wr_req;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= kfef_pkg::VcReset;
    end else if (cfg_i.valid) begin
      vc_q <= cfg_i.data;
    end
  end

  // Effective vertex count: clamp to 1 .. Depth.
  always_comb begin
    if (vc_q == '0) begin
      n_d = kfef_pkg::VcW'(1);
    end else if (vc_q > Cap) begin
      n_d = Cap;
    end else begin
      n_d = vc_q;
    end
  end
  assign need_d      = kfef_pkg::CntW'(n_d - kfef_pkg::VcW'(1));
  assign taken_start = in_i.data.first_edge ? '0 : taken_q;
  assign edge_ok     = ({1'b0, in_i.data.source} < n_d) &&
                       ({1'b0, in_i.data.destination} < n_d) &&
                       (taken_start < need_d);

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  // Table read data arrives in S_CHECK for vertex v_q.
  assign parent   = rd_data;
  assign is_root  = (parent == v_q) || ({1'b0, parent} >= n_q);
  // A walk that has taken the full step budget ends at the vertex it reached.
  assign walk_end = is_root || (steps_q == StepMax);

  // Result register loads when the sequencer is done and the register is free.
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  always_comb begin
    rd_req.en   = (state_q == S_READ);
    rd_req.addr = v_q;
    wr_req.clear = in_fire && in_i.data.first_edge;
    wr_req.en    = (state_q == S_CHECK) && phase_q && walk_end && (rs_q != v_q);
    wr_req.addr  = rs_q;
    wr_req.data  = v_q;
  end

  kfef_parent_table #(
    .Depth (Depth),
    .IdxW  (IdxW)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_req_i  (rd_req),
    .wr_req_i  (wr_req),
    .rd_data_o (rd_data)
  );

  // Sequencer, count and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= 1'b0;
      taken_q     <= '0;
      steps_q     <= '0;
      acc_q       <= 1'b0;
      out_valid_q <= 1'b0;
      n_q         <= kfef_pkg::VcReset;
      need_q      <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            src_q    <= in_i.data.source;
            dst_q    <= in_i.data.destination;
            weight_q <= in_i.data.weight;
            n_q      <= n_d;
            need_q   <= need_d;
            taken_q  <= taken_start;
            acc_q    <= 1'b0;
            v_q      <= in_i.data.source;
            phase_q  <= 1'b0;
            steps_q  <= '0;
            state_q  <= edge_ok ? S_READ : S_DONE;
          end
        end
        S_READ: begin
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          if (!walk_end) begin
            v_q     <= parent;
            steps_q <= steps_q + 9'd1;
            state_q <= S_READ;
          end else if (!phase_q) begin
            rs_q    <= v_q;
            v_q     <= dst_q;
            phase_q <= 1'b1;
            steps_q <= '0;
            state_q <= S_READ;
          end else begin
            if (rs_q != v_q) begin
              taken_q <= taken_q + kfef_pkg::CntW'(1);
              acc_q   <= 1'b1;
            end
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_q.accepted      <= acc_q;
            out_q.low_end       <= (src_q < dst_q) ? src_q : dst_q;
            out_q.high_end      <= (src_q < dst_q) ? dst_q : src_q;
            out_q.edge_weight   <= weight_q;
            out_q.edges_taken   <= taken_q;
            out_q.tree_complete <= (taken_q >= need_q);
            state_q             <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

`ifndef SYNTHESIS
  // A link is written only between two distinct roots.
  a_link_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_req.en |-> (wr_req.addr != wr_req.data))
    else $error("parent link written onto itself");

  // A new result word is only loaded from the finish state.
  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_DONE))
    else $error("result loaded outside finish state");

  // An accepted edge always reports a nonzero count.
  a_acc_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.accepted) |-> (out_q.edges_taken != '0))
    else $error("accepted edge with zero count");

  // A stalled result word stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> (out_valid_q && $stable(out_q)))
    else $error("result word changed while stalled");
`endif

endmodule

[tb/tb.sv]
// Self-checking testbench for the Kruskal forest edge filter: directed edges, then random graphs.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned     VtxW       = kfef_pkg::VtxW;
  localparam int unsigned     CntW       = kfef_pkg::CntW;
  localparam int unsigned     VcW        = kfef_pkg::VcW;
  localparam int unsigned     WeightW    = kfef_pkg::WeightW;
  localparam logic [VcW-1:0]  VcReset    = kfef_pkg::VcReset;
  typedef kfef_pkg::in_word_t  in_word_t;
  typedef kfef_pkg::out_word_t out_word_t;

  localparam int unsigned     MaxVtx     = 256;
  localparam int unsigned     DrainPad   = 8;
  // Cycle limit for the whole run; real runs stay far below it.
  localparam longint unsigned CycleLimit = 20_000_000;
  localparam int unsigned     MaxPrints  = 100;

  // Union-find mirror of the block plus the queue of result words still owed.
  class forest_scoreboard;
    logic [VtxW-1:0] parent_of [MaxVtx];
    logic [CntW-1:0] taken;
    logic [VcW-1:0]  vcount;
    out_word_t       owed [$];
    int unsigned     errors;

    function new();
      vcount = VcReset;
      errors = 0;
      clear_forest();
    endfunction

    function void clear_forest();
      for (int v = 0; v < MaxVtx; v++) parent_of[v] = v[VtxW-1:0];
      taken = '0;
    endfunction

    // Register value saturated to 1 .. MaxVtx.
    function int unsigned eff_vertices();
      int unsigned n;
      n = vcount;
      if (n < 1) n = 1;
      if (n > MaxVtx) n = MaxVtx;
      return n;
    endfunction

    function int unsigned root_of(int unsigned v, int unsigned n);
      int unsigned p;
      for (int s = 0; s < 256; s++) begin
        if (v >= n) break;
        p = parent_of[v];
        if (p == v || p >= n) break;
        v = p;
      end
      return v;
    endfunction

    // Accepted edge word: advance the forest and queue the word it must produce.
    function void note_edge(in_word_t w);
      int unsigned n, rs, rd;
      out_word_t   e;
      n = eff_vertices();
      if (w.first_edge) clear_forest();
      e = '0;
      if (w.source < n && w.destination < n && taken < n - 1) begin
        rs = root_of(w.source, n);
        rd = root_of(w.destination, n);
        if (rs != rd) begin
          parent_of[rs] = rd[VtxW-1:0];
          taken = taken + 1'b1;
          e.accepted = 1'b1;
        end
      end
      e.low_end       = (w.source < w.destination) ? w.source : w.destination;
      e.high_end      = (w.source < w.destination) ? w.destination : w.source;
      e.edge_weight   = w.weight;
      e.edges_taken   = taken;
      e.tree_complete = (taken >= n - 1);
      owed.push_back(e);
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
      errors++;
      if (errors <= MaxPrints)
        $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    task check_result(out_word_t got);
      out_word_t want;
      if (owed.size() == 0) begin
        report("result word with none owed", got.edges_taken, 0);
        return;
      end
      want = owed.pop_front();
      if (got.accepted !== want.accepted) report("accepted", got.accepted, want.accepted);
      if (got.low_end !== want.low_end) report("low_end", got.low_end, want.low_end);
      if (got.high_end !== want.high_end) report("high_end", got.high_end, want.high_end);
      if (got.edge_weight !== want.edge_weight)
        report("edge_weight", $unsigned(got.edge_weight), $unsigned(want.edge_weight));
      if (got.edges_taken !== want.edges_taken)
        report("edges_taken", got.edges_taken, want.edges_taken);
      if (got.tree_complete !== want.tree_complete)
        report("tree_complete", got.tree_complete, want.tree_complete);
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  kfef_in_if  in_if ();
  kfef_out_if out_if ();
  kfef_cfg_if cfg_if ();

  kruskal_forest_edge_filter_unit #(.MAX_VERTICES(MaxVtx)) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  forest_scoreboard sb;
  int unsigned      snd_idle_pct  = 0;
  int unsigned      rcv_stall_pct = 0;
  int unsigned      edges_sent    = 0;
  int unsigned      edge_target   = 0;
  longint unsigned  cycles        = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Result side: random back-pressure, words checked at the rising edge.
  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_if.valid && out_if.ready) sb.check_result(out_if.data);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[kruskal_forest_edge_filter_unit] ERROR");
      $finish;
    end
  end

  function automatic in_word_t edge_word(logic first, logic [VtxW-1:0] s,
                                         logic [VtxW-1:0] d, logic [WeightW-1:0] w);
    in_word_t e;
    e.first_edge  = first;
    e.source      = s;
    e.destination = d;
    e.weight      = w;
    return e;
  endfunction

  // Mostly in range, now and then anywhere in the 8-bit space.
  function automatic logic [VtxW-1:0] pick_vertex(int unsigned n);
    if ($urandom_range(9) == 0) return VtxW'($urandom_range(255));
    return VtxW'($urandom_range(n - 1));
  endfunction

  function automatic logic [VcW-1:0] pick_count();
    case ($urandom_range(39))
      0:          return '0;
      1:          return 9'd1;
      2:          return 9'd256;
      3:          return 9'($urandom_range(511, 257));
      4:          return 9'd255;
      5, 6, 7, 8: return 9'($urandom_range(100, 25));
      default:    return 9'($urandom_range(16, 2));
    endcase
  endfunction

  // Word stays valid from one handshake into the next unless the sender idles.
  task automatic send_edge(in_word_t w);
    @(negedge clk_i);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= w;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_edge(w);
    edges_sent++;
  endtask

  task automatic write_vertex_count(logic [VcW-1:0] vc);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= vc;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.vcount = vc;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Hold the sender until every owed word is back, then let the block settle.
  task automatic drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (DrainPad) @(posedge clk_i);
  endtask

  // One graph: a random spanning tree in shuffled order, padded with redundant
  // edges, stray edges and noise words; a few edges more after completion.
  task automatic random_graph();
    int unsigned     n, ne, t, j, tail;
    logic [VtxW-1:0] perm [MaxVtx];
    logic [VtxW-1:0] ea [MaxVtx];
    logic [VtxW-1:0] eb [MaxVtx];
    logic [VtxW-1:0] s, d, tmp;
    logic [WeightW-1:0] w;
    logic            first;
    n = sb.eff_vertices();
    for (int i = 0; i < n; i++) perm[i] = i[VtxW-1:0];
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = perm[i]; perm[i] = perm[j]; perm[j] = tmp;
    end
    ne = n - 1;
    for (int i = 1; i < n; i++) begin
      j = $urandom_range(i - 1);
      ea[i-1] = perm[i];
      eb[i-1] = perm[j];
    end
    for (int i = ne - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = ea[i]; ea[i] = ea[j]; ea[j] = tmp;
      tmp = eb[i]; eb[i] = eb[j]; eb[j] = tmp;
    end
    w     = $urandom;
    first = 1'b1;
    t     = 0;
    tail  = $urandom_range(4, 1);
    while ((t < ne || tail != 0) && edges_sent < edge_target) begin
      w = w + $urandom_range(1000);
      if ($urandom_range(19) == 0) begin
        send_edge(edge_word($urandom_range(7) == 0, VtxW'($urandom_range(255)),
                            VtxW'($urandom_range(255)), $urandom));
      end else begin
        if (t < ne && $urandom_range(3) != 0) begin
          s = ea[t];
          d = eb[t];
          t++;
          if ($urandom_range(1)) begin
            tmp = s; s = d; d = tmp;
          end
        end else begin
          s = pick_vertex(n);
          d = pick_vertex(n);
          if (t >= ne) tail--;
        end
        send_edge(edge_word(first, s, d, w));
        first = 1'b0;
      end
    end
  endtask

  task automatic run_phase(int unsigned snd_pct, int unsigned rcv_pct, int unsigned items);
    bit fresh;
    drain();
    snd_idle_pct  = snd_pct;
    rcv_stall_pct = rcv_pct;
    edge_target   = edges_sent + items;
    fresh         = 1'b1;
    while (edges_sent < edge_target) begin
      if (fresh || $urandom_range(2) == 0) begin
        drain();
        write_vertex_count(pick_count());
      end
      fresh = 1'b0;
      random_graph();
    end
  endtask

  initial begin
    sb            = new();
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.data    = '0;
    out_if.ready  = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Four-vertex graph: joins, same-tree edge, self loop, endpoints out of
    // range, completion, edges after completion, then a fresh start.
    edge_target = ~0;
    write_vertex_count(9'd4);
    send_edge(edge_word(1'b1, 8'd0, 8'd1, 32'h8000_0000));
    send_edge(edge_word(1'b0, 8'd1, 8'd0, 32'hffff_fffb));
    send_edge(edge_word(1'b0, 8'd2, 8'd2, 32'h0000_0000));
    send_edge(edge_word(1'b0, 8'd5, 8'd1, 32'h0000_0001));
    send_edge(edge_word(1'b0, 8'd3, 8'd255, 32'h0000_0002));
    send_edge(edge_word(1'b0, 8'd3, 8'd2, 32'h0000_0003));
    send_edge(edge_word(1'b0, 8'd2, 8'd0, 32'hffff_ffff));
    send_edge(edge_word(1'b0, 8'd1, 8'd3, 32'h0000_0007));
    send_edge(edge_word(1'b1, 8'd3, 8'd0, 32'h7fff_ffff));
    // Count of zero acts as one vertex; the forest survives the change.
    drain();
    write_vertex_count(9'd0);
    send_edge(edge_word(1'b0, 8'd0, 8'd0, 32'h0000_0004));
    // Above 256 saturates; old links still count.
    drain();
    write_vertex_count(9'd300);
    send_edge(edge_word(1'b0, 8'd255, 8'd0, 32'h0000_0005));
    send_edge(edge_word(1'b0, 8'd254, 8'd128, 32'h0000_0006));
    send_edge(edge_word(1'b0, 8'd128, 8'd255, 32'h0000_0007));
    drain();
    write_vertex_count(9'd511);
    send_edge(edge_word(1'b1, 8'd255, 8'd255, 32'h0000_0008));
    send_edge(edge_word(1'b0, 8'd0, 8'd255, 32'h0000_0009));
    drain();
    write_vertex_count(9'd2);
    send_edge(edge_word(1'b1, 8'd1, 8'd0, 32'h0000_000a));
    send_edge(edge_word(1'b0, 8'd0, 8'd1, 32'h0000_000b));
    send_edge(edge_word(1'b0, 8'd2, 8'd0, 32'h0000_000c));
    drain();
    write_vertex_count(9'd1);
    send_edge(edge_word(1'b1, 8'd0, 8'd0, 32'h0000_000d));
    send_edge(edge_word(1'b0, 8'd0, 8'd1, 32'h0000_000e));

    // Random graphs under each idling mix.
    run_phase(0, 0, 313);
    run_phase(57, 0, 313);
    run_phase(0, 57, 312);
    run_phase(29, 29, 312);
    drain();

    if (sb.errors == 0) begin
      $display("[kruskal_forest_edge_filter_unit] OK");
    end else begin
      $display("[kruskal_forest_edge_filter_unit] ERROR");
    end
    $finish;
  end

endmodule
